// ===== sv/lcg_pkg.sv =====
`timescale 1ns / 1ps

package lcg_pkg;

   // Default width of the generator state.
   localparam int VALUE_WIDTH_DEFAULT = 16;

   // Fixed field widths of the ports.
   localparam int MOD_REG_W = 17;
   localparam int SETTING_W = 32;
   localparam int RESULT_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Width of the raised factor and increment (both stay below 8000).
   localparam int FIX_W = 13;

   // Bit counter for the serial passes; the longest pass is SETTING_W bits.
   localparam int CNT_W = 5;

   localparam logic [MOD_REG_W-1:0] MODULUS_RESET = 17'd32768;
   localparam logic [FIX_W-1:0]     FACTOR_MIN    = 13'd4000;
   localparam logic [FIX_W-1:0]     INCREMENT_MIN = 13'd3000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS   = 2'd0,
      CSR_FACTOR    = 2'd1,
      CSR_INCREMENT = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_NEXT = 1'b0,
      OP_SEED = 1'b1
   } opcode_type;

endpackage

// ===== sv/lcg_random_generator_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_opcode, req_seed_value
// rsp       out        rsp_valid/rsp_ready  rsp_random_value
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// A next item's result is registered after the settings are reduced (ST_DIVIDE), fixed up
// (ST_FIXUP), the raised constants reduced (ST_REDUCE), one state bit multiplied per step
// (ST_MULT) and the result written (ST_FINISH).
// A seed item loads the state at the end of the division pass; after either kind the
// unit returns to idle, where the next transfer is taken.
// Reset is synchronous; it restores the register defaults and clears the state.
// A stalled result stays in the output register; the next item is taken meanwhile
// and waits only at its own final step until the output register frees up.

module lcg_random_generator_unit #(
   parameter int VALUE_WIDTH = lcg_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [lcg_pkg::SETTING_W-1:0]  req_seed_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lcg_pkg::RESULT_W-1:0]   rsp_random_value,
   input  logic                           csr_wr_en,
   input  logic [lcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcg_pkg::*;

   // Working width: holds the modulus and every residue below it.
   localparam int W = (VALUE_WIDTH + 1 > MOD_REG_W) ? VALUE_WIDTH + 1 : MOD_REG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FIXUP,
      ST_REDUCE,
      ST_MULT,
      ST_FINISH
   } fsm_type;

   fsm_type                 fsm_ff;
   logic [MOD_REG_W-1:0]    mod_ff;
   logic [SETTING_W-1:0]    factor_ff;
   logic [SETTING_W-1:0]    incr_ff;
   logic [VALUE_WIDTH-1:0]  state_ff;
   logic                    op_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [SETTING_W-1:0]    sh0_ff;
   logic [SETTING_W-1:0]    sh1_ff;
   logic [W-1:0]            rem0_ff;
   logic [W-1:0]            rem1_ff;
   logic [W-1:0]            a_ff;
   logic [W-1:0]            c_ff;
   logic                    a_low_ff;
   logic                    c_low_ff;
   logic [W-1:0]            d_ff;
   logic [W-1:0]            acc_ff;
   logic [VALUE_WIDTH-1:0]  xs_ff;
   logic                    rsp_valid_ff;
   logic [RESULT_W-1:0]     rsp_data_ff;

   logic [W-1:0]            m_eff;
   logic [W-1:0]            limit;
   logic [W-1:0]            rem0_in;
   logic [W-1:0]            rem1_in;
   logic [1:0]              a_bump;
   logic [W-1:0]            a_fix;
   logic [W-1:0]            c_fix;
   logic                    a_low;
   logic                    c_low;
   logic [FIX_W-1:0]        a_raised;
   logic [FIX_W-1:0]        c_raised;
   logic [W-1:0]            acc_in;
   logic [W-1:0]            d_in;
   logic [W-1:0]            result_in;
   logic                    rsp_free;

   // One restoring step: append a bit to a residue and reduce it once.
   function automatic logic [W-1:0] mod_shift(input logic [W-1:0] r, input logic b,
                                              input logic [W-1:0] m);
      logic [W:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[W-1:0];
   endfunction

   // Sum of two values whose total stays below twice the modulus.
   function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      logic [W:0] t;
      t = {1'b0, x} + {1'b0, y};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[W-1:0];
   endfunction

   always_comb begin
      limit = W'(1) << VALUE_WIDTH;
      if (mod_ff == '0) begin
         m_eff = W'(1);
      end else if (W'(mod_ff) > limit) begin
         m_eff = limit;
      end else begin
         m_eff = W'(mod_ff);
      end

      rem0_in = mod_shift(rem0_ff, sh0_ff[SETTING_W-1], m_eff);
      rem1_in = mod_shift(rem1_ff, sh1_ff[SETTING_W-1], m_eff);

      // Move the reduced factor up to the next value that is 1 mod 4.
      case (rem0_ff[1:0])
         2'd0:    a_bump = 2'd1;
         2'd1:    a_bump = 2'd0;
         2'd2:    a_bump = 2'd3;
         default: a_bump = 2'd2;
      endcase
      a_fix    = mod_add(rem0_ff, W'(a_bump), m_eff);
      c_fix    = mod_add(rem1_ff, W'(!rem1_ff[0]), m_eff);
      a_low    = a_fix < W'(FACTOR_MIN);
      c_low    = c_fix < W'(INCREMENT_MIN);
      a_raised = a_fix[FIX_W-1:0] + FACTOR_MIN;
      c_raised = c_fix[FIX_W-1:0] + INCREMENT_MIN;

      // The product is built from the low state bit upward: d holds a * 2^i mod m.
      acc_in    = xs_ff[0] ? mod_add(acc_ff, d_ff, m_eff) : acc_ff;
      d_in      = mod_shift(d_ff, 1'b0, m_eff);
      result_in = mod_add(acc_ff, c_ff, m_eff);

      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         mod_ff       <= MODULUS_RESET;
         factor_ff    <= '0;
         incr_ff      <= '0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODULUS:   mod_ff    <= csr_wdata[MOD_REG_W-1:0];
               CSR_FACTOR:    factor_ff <= csr_wdata[SETTING_W-1:0];
               CSR_INCREMENT: incr_ff   <= csr_wdata[SETTING_W-1:0];
               default:       ;
            endcase
         end

         // In the final step the output register is refilled there instead.
         if (rsp_valid_ff && rsp_ready && (fsm_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (fsm_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_opcode;
                  sh0_ff  <= (req_opcode == OP_SEED) ? req_seed_value : factor_ff;
                  sh1_ff  <= incr_ff;
                  rem0_ff <= '0;
                  rem1_ff <= '0;
                  cnt_ff  <= CNT_W'(SETTING_W - 1);
                  fsm_ff  <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               rem0_ff <= rem0_in;
               rem1_ff <= rem1_in;
               sh0_ff  <= {sh0_ff[SETTING_W-2:0], 1'b0};
               sh1_ff  <= {sh1_ff[SETTING_W-2:0], 1'b0};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  if (op_ff == OP_SEED) begin
                     state_ff <= rem0_in[VALUE_WIDTH-1:0];
                     fsm_ff   <= ST_IDLE;
                  end else begin
                     fsm_ff <= ST_FIXUP;
                  end
               end
            end
            ST_FIXUP: begin
               a_ff     <= a_fix;
               c_ff     <= c_fix;
               a_low_ff <= a_low;
               c_low_ff <= c_low;
               // Raised constants may exceed a small modulus and get reduced again.
               sh0_ff   <= {a_raised, {(SETTING_W - FIX_W){1'b0}}};
               sh1_ff   <= {c_raised, {(SETTING_W - FIX_W){1'b0}}};
               rem0_ff  <= '0;
               rem1_ff  <= '0;
               cnt_ff   <= CNT_W'(FIX_W - 1);
               fsm_ff   <= ST_REDUCE;
            end
            ST_REDUCE: begin
               rem0_ff <= rem0_in;
               rem1_ff <= rem1_in;
               sh0_ff  <= {sh0_ff[SETTING_W-2:0], 1'b0};
               sh1_ff  <= {sh1_ff[SETTING_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  d_ff   <= a_low_ff ? rem0_in : a_ff;
                  c_ff   <= c_low_ff ? rem1_in : c_ff;
                  acc_ff <= '0;
                  xs_ff  <= state_ff;
                  cnt_ff <= CNT_W'(VALUE_WIDTH - 1);
                  fsm_ff <= ST_MULT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_MULT: begin
               acc_ff <= acc_in;
               d_ff   <= d_in;
               xs_ff  <= xs_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  fsm_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff     <= result_in[VALUE_WIDTH-1:0];
                  rsp_data_ff  <= result_in[RESULT_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  fsm_ff       <= ST_IDLE;
               end
            end
            default: begin
               fsm_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = (fsm_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;

   a_req_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (fsm_ff == ST_DIVIDE))
      else $error("Accepted request did not start the division pass.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff == ST_FINISH))
      else $error("Result appeared outside the final step.");

   a_state_update_point: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(state_ff)) |->
         ($past(fsm_ff == ST_DIVIDE) || $past(fsm_ff == ST_FINISH)))
      else $error("Generator state changed outside a seed load or a step.");

   a_mult_is_next: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_MULT) |-> (op_ff == OP_NEXT))
      else $error("Multiply pass running for a seed item.");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (fsm_ff == ST_FINISH))
      else $error("Final step overwrote a result that was not transferred.");

endmodule
